>>> sv/single_head_attention_unit_defines.svh
// Assertion macros for the attention unit RTL.
`ifndef SINGLE_HEAD_ATTENTION_UNIT_DEFINES_SVH
`define SINGLE_HEAD_ATTENTION_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
// Check prop on every rising edge outside reset.
`define SHA_ASSERT(name, clk, rstn, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
// Check prop on every rising edge, reset included.
`define SHA_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define SHA_ASSERT(name, clk, rstn, prop, msg)
`define SHA_ASSERT_ALWAYS(name, clk, prop, msg)
`endif

`endif

>>> sv/sha_pkg.sv
package sha_pkg;

  localparam int DEF_MAX_TOKENS = 128;
  localparam int DEF_MAX_DIM    = 64;

  localparam int SCORE_W   = 40;
  localparam int ELEM_W    = 16;
  localparam int EXP_W     = 17;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 8;

  localparam logic [1:0] CMD_LOAD_Q  = 2'd0;
  localparam logic [1:0] CMD_LOAD_KV = 2'd1;
  localparam logic [1:0] CMD_COMPUTE = 2'd2;
  localparam logic [1:0] CMD_READ    = 2'd3;

  localparam logic KIND_OUTPUT = 1'b0;
  localparam logic KIND_SCORE  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_TOKEN_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIM_COUNT   = 2'd1;

  localparam logic [7:0] TOKEN_COUNT_RST = 8'd128;
  localparam logic [6:0] DIM_COUNT_RST   = 7'd64;

  localparam logic [16:0] LOG2E_Q16 = 17'd94548;

  typedef struct packed {
    logic [1:0]               cmd;
    logic [6:0]               token_index;
    logic [5:0]               dim_index;
    logic signed [ELEM_W-1:0] query_elem;
    logic signed [ELEM_W-1:0] key_elem;
    logic signed [ELEM_W-1:0] value_elem;
  } in_item_t;

  typedef struct packed {
    logic                      kind;
    logic [6:0]                index;
    logic signed [SCORE_W-1:0] value;
    logic                      last;
  } out_item_t;

  typedef struct packed {
    logic ld_q;
    logic ld_kv;
    logic sc_issue;
    logic sc_first_elem;
    logic sc_last_elem;
    logic sc_first_tok;
    logic ex_issue;
    logic ex_first;
    logic nm_rd;
    logic nm_start;
    logic nm_wr;
    logic op_issue;
    logic op_first;
    logic op_emit;
    logic emit_last;
    logic rd_issue;
    logic rd_emit;
  } sha_cmd_t;

  typedef struct packed {
    logic pipe_busy;
    logic div_busy;
    logic out_free;
  } sha_status_t;

  // 65536 * 2^(-f/32), rounded
  function automatic logic [EXP_W-1:0] exp2_frac(input logic [4:0] f);
    logic [EXP_W-1:0] r;
    unique case (f)
      5'd0:  r = 17'd65536;  5'd1:  r = 17'd64132;  5'd2:  r = 17'd62757;
      5'd3:  r = 17'd61413;  5'd4:  r = 17'd60097;  5'd5:  r = 17'd58809;
      5'd6:  r = 17'd57549;  5'd7:  r = 17'd56316;  5'd8:  r = 17'd55109;
      5'd9:  r = 17'd53928;  5'd10: r = 17'd52773;  5'd11: r = 17'd51642;
      5'd12: r = 17'd50535;  5'd13: r = 17'd49452;  5'd14: r = 17'd48393;
      5'd15: r = 17'd47356;  5'd16: r = 17'd46341;  5'd17: r = 17'd45348;
      5'd18: r = 17'd44376;  5'd19: r = 17'd43425;  5'd20: r = 17'd42495;
      5'd21: r = 17'd41584;  5'd22: r = 17'd40694;  5'd23: r = 17'd39822;
      5'd24: r = 17'd38968;  5'd25: r = 17'd38133;  5'd26: r = 17'd37316;
      5'd27: r = 17'd36516;  5'd28: r = 17'd35734;  5'd29: r = 17'd34968;
      5'd30: r = 17'd34219;  5'd31: r = 17'd33486;
      default: r = 17'd65536;
    endcase
    return r;
  endfunction

endpackage

>>> sv/sha_div.sv
module sha_div #(
  parameter int DVD_W = 33,
  parameter int DVS_W = 24
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             busy,
  output logic [DVD_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [CNT_W-1:0] cnt_r;
  logic [DVS_W:0]   rem_r;
  logic [DVD_W-1:0] quo_r;
  logic [DVS_W-1:0] dvs_r;
  logic [DVS_W:0]   trial;
  logic             take;

  // restoring division, one quotient bit per cycle
  assign trial = {rem_r[DVS_W-1:0], quo_r[DVD_W-1]};
  assign take  = trial >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= CNT_W'(DVD_W);
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (cnt_r != '0) begin
      rem_r <= take ? (trial - {1'b0, dvs_r}) : trial;
      quo_r <= {quo_r[DVD_W-2:0], take};
    end
  end

  assign busy     = cnt_r != '0;
  assign quotient = quo_r;

endmodule

>>> sv/sha_ctrl.sv
`include "single_head_attention_unit_defines.svh"

module sha_ctrl #(
  parameter int MAX_TOKENS = sha_pkg::DEF_MAX_TOKENS,
  parameter int MAX_DIM    = sha_pkg::DEF_MAX_DIM,
  localparam int TIW = (MAX_TOKENS > 1) ? $clog2(MAX_TOKENS) : 1,
  localparam int DIW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [1:0]                     in_cmd,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [sha_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sha_pkg::CFG_DAT_W-1:0]  cfg_data,
  input  sha_pkg::sha_status_t           status,
  output sha_pkg::sha_cmd_t              cmd,
  output logic [TIW-1:0]                 tok_idx,
  output logic [DIW-1:0]                 dim_idx
);

  localparam int TCW = $clog2(MAX_TOKENS + 1);
  localparam int DCW = $clog2(MAX_DIM + 1);

  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_RD_EMIT  = 4'd1;
  localparam logic [3:0] ST_SC_RUN   = 4'd2;
  localparam logic [3:0] ST_SC_DRAIN = 4'd3;
  localparam logic [3:0] ST_EX_RUN   = 4'd4;
  localparam logic [3:0] ST_EX_DRAIN = 4'd5;
  localparam logic [3:0] ST_NM_RD    = 4'd6;
  localparam logic [3:0] ST_NM_START = 4'd7;
  localparam logic [3:0] ST_NM_WAIT  = 4'd8;
  localparam logic [3:0] ST_NM_WR    = 4'd9;
  localparam logic [3:0] ST_OP_RUN   = 4'd10;
  localparam logic [3:0] ST_OP_DRAIN = 4'd11;
  localparam logic [3:0] ST_OP_EMIT  = 4'd12;

  logic [3:0]     state_r, state_nxt;
  logic [TIW-1:0] t_r, t_nxt;
  logic [DIW-1:0] d_r, d_nxt;
  logic [7:0]     token_count_r;
  logic [6:0]     dim_count_r;
  logic [TCW-1:0] nt;
  logic [DCW-1:0] nd;
  logic           t_last, d_last;

  // clamp counts to 1..max
  always_comb begin
    if (token_count_r == '0) begin
      nt = TCW'(1);
    end else if (32'(token_count_r) > MAX_TOKENS) begin
      nt = TCW'(MAX_TOKENS);
    end else begin
      nt = TCW'(token_count_r);
    end
    if (dim_count_r == '0) begin
      nd = DCW'(1);
    end else if (32'(dim_count_r) > MAX_DIM) begin
      nd = DCW'(MAX_DIM);
    end else begin
      nd = DCW'(dim_count_r);
    end
  end

  assign t_last = t_r == TIW'(nt - TCW'(1));
  assign d_last = d_r == DIW'(nd - DCW'(1));

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      token_count_r <= sha_pkg::TOKEN_COUNT_RST;
      dim_count_r   <= sha_pkg::DIM_COUNT_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        sha_pkg::REG_TOKEN_COUNT: token_count_r <= cfg_data;
        sha_pkg::REG_DIM_COUNT:   dim_count_r   <= cfg_data[6:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    t_nxt     = t_r;
    d_nxt     = d_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          unique case (in_cmd)
            sha_pkg::CMD_LOAD_Q:  cmd.ld_q  = 1'b1;
            sha_pkg::CMD_LOAD_KV: cmd.ld_kv = 1'b1;
            sha_pkg::CMD_READ: begin
              cmd.rd_issue = 1'b1;
              state_nxt    = ST_RD_EMIT;
            end
            sha_pkg::CMD_COMPUTE: begin
              t_nxt     = '0;
              d_nxt     = '0;
              state_nxt = ST_SC_RUN;
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_RD_EMIT: begin
        if (status.out_free) begin
          cmd.rd_emit = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      ST_SC_RUN: begin
        cmd.sc_issue      = 1'b1;
        cmd.sc_first_elem = d_r == '0;
        cmd.sc_last_elem  = d_last;
        cmd.sc_first_tok  = t_r == '0;
        if (d_last) begin
          d_nxt = '0;
          if (t_last) begin
            state_nxt = ST_SC_DRAIN;
          end else begin
            t_nxt = t_r + 1'b1;
          end
        end else begin
          d_nxt = d_r + 1'b1;
        end
      end
      ST_SC_DRAIN: begin
        if (!status.pipe_busy) begin
          t_nxt     = '0;
          state_nxt = ST_EX_RUN;
        end
      end
      ST_EX_RUN: begin
        cmd.ex_issue = 1'b1;
        cmd.ex_first = t_r == '0;
        if (t_last) begin
          state_nxt = ST_EX_DRAIN;
        end else begin
          t_nxt = t_r + 1'b1;
        end
      end
      ST_EX_DRAIN: begin
        if (!status.pipe_busy) begin
          t_nxt     = '0;
          state_nxt = ST_NM_RD;
        end
      end
      ST_NM_RD: begin
        cmd.nm_rd = 1'b1;
        state_nxt = ST_NM_START;
      end
      ST_NM_START: begin
        cmd.nm_start = 1'b1;
        state_nxt    = ST_NM_WAIT;
      end
      ST_NM_WAIT: begin
        if (!status.div_busy) begin
          state_nxt = ST_NM_WR;
        end
      end
      ST_NM_WR: begin
        cmd.nm_wr = 1'b1;
        if (t_last) begin
          t_nxt     = '0;
          d_nxt     = '0;
          state_nxt = ST_OP_RUN;
        end else begin
          t_nxt     = t_r + 1'b1;
          state_nxt = ST_NM_RD;
        end
      end
      ST_OP_RUN: begin
        cmd.op_issue = 1'b1;
        cmd.op_first = t_r == '0;
        if (t_last) begin
          state_nxt = ST_OP_DRAIN;
        end else begin
          t_nxt = t_r + 1'b1;
        end
      end
      ST_OP_DRAIN: begin
        if (!status.pipe_busy) begin
          state_nxt = ST_OP_EMIT;
        end
      end
      ST_OP_EMIT: begin
        if (status.out_free) begin
          cmd.op_emit   = 1'b1;
          cmd.emit_last = d_last;
          t_nxt         = '0;
          if (d_last) begin
            state_nxt = ST_IDLE;
          end else begin
            d_nxt     = d_r + 1'b1;
            state_nxt = ST_OP_RUN;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      t_r     <= '0;
      d_r     <= '0;
    end else begin
      state_r <= state_nxt;
      t_r     <= t_nxt;
      d_r     <= d_nxt;
    end
  end

  assign tok_idx = t_r;
  assign dim_idx = d_r;

  `SHA_ASSERT(a_emit_slot_free, clk, rst_n, (cmd.op_emit || cmd.rd_emit) |-> status.out_free, "emit into an occupied output slot")
  `SHA_ASSERT(a_one_phase, clk, rst_n, $onehot0({cmd.sc_issue, cmd.ex_issue, cmd.nm_rd, cmd.op_issue, cmd.rd_issue}), "two phases issued at once")
  `SHA_ASSERT(a_div_done_before_wr, clk, rst_n, cmd.nm_wr |-> (!status.div_busy && $past(state_r) == ST_NM_WAIT), "weight written before divide finished")

endmodule

>>> sv/sha_dp.sv
module sha_dp #(
  parameter int MAX_TOKENS = sha_pkg::DEF_MAX_TOKENS,
  parameter int MAX_DIM    = sha_pkg::DEF_MAX_DIM,
  localparam int TIW = (MAX_TOKENS > 1) ? $clog2(MAX_TOKENS) : 1,
  localparam int DIW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  sha_pkg::in_item_t    in_item,
  input  sha_pkg::sha_cmd_t    cmd,
  input  logic [TIW-1:0]       tok_idx,
  input  logic [DIW-1:0]       dim_idx,
  output sha_pkg::sha_status_t status,
  output logic                 out_valid,
  input  logic                 out_ready,
  output sha_pkg::out_item_t   out_item
);

  localparam int KV_DEPTH = MAX_TOKENS * MAX_DIM;
  localparam int AW       = (KV_DEPTH > 1) ? $clog2(KV_DEPTH) : 1;
  localparam int SW       = sha_pkg::SCORE_W;
  localparam int EW       = sha_pkg::EXP_W;
  localparam int SUM_W    = EW + TIW;
  localparam int OACC_W   = 33 + TIW;
  localparam int DVD_W    = EW + 16;
  localparam int ROUND_HALF = 32768;

  // storage
  logic signed [15:0]   q_mem  [MAX_DIM];
  logic signed [15:0]   k_mem  [KV_DEPTH];
  logic signed [15:0]   v_mem  [KV_DEPTH];
  logic signed [SW-1:0] s_mem  [MAX_TOKENS];
  logic [EW-1:0]        wt_mem [MAX_TOKENS];

  logic signed [15:0]   q_rd_r, k_rd_r, v_rd_r;
  logic signed [SW-1:0] s_rd_r;
  logic [EW-1:0]        wt_rd_r;

  logic [AW-1:0]  kv_addr, ld_addr;
  logic [TIW-1:0] ld_tok, s_raddr;
  logic [DIW-1:0] ld_dim;
  logic           tok_ok, dim_ok;

  assign tok_ok  = 32'(in_item.token_index) < MAX_TOKENS;
  assign dim_ok  = 32'(in_item.dim_index) < MAX_DIM;
  assign ld_tok  = TIW'(in_item.token_index);
  assign ld_dim  = DIW'(in_item.dim_index);
  assign kv_addr = AW'(tok_idx) * AW'(MAX_DIM) + AW'(dim_idx);
  assign ld_addr = AW'(ld_tok) * AW'(MAX_DIM) + AW'(ld_dim);
  assign s_raddr = cmd.rd_issue ? ld_tok : tok_idx;

  always_ff @(posedge clk) begin
    if (cmd.ld_q && dim_ok) begin
      q_mem[ld_dim] <= in_item.query_elem;
    end
    q_rd_r <= q_mem[dim_idx];
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_kv && dim_ok && tok_ok) begin
      k_mem[ld_addr] <= in_item.key_elem;
      v_mem[ld_addr] <= in_item.value_elem;
    end
    k_rd_r <= k_mem[kv_addr];
    v_rd_r <= v_mem[kv_addr];
  end

  // score pipeline: read, multiply, accumulate, store and track maximum
  logic                 sc_v1_r, sc_v2_r, sc_v3_r;
  logic                 sc_fe1_r, sc_fe2_r, sc_le1_r, sc_le2_r;
  logic                 sc_ft1_r, sc_ft2_r, sc_ft3_r;
  logic [TIW-1:0]       sc_tok1_r, sc_tok2_r, sc_tok3_r;
  logic signed [31:0]   sc_prod_r;
  logic signed [SW-1:0] sc_acc_r, best_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sc_v1_r <= 1'b0;
      sc_v2_r <= 1'b0;
      sc_v3_r <= 1'b0;
    end else begin
      sc_v1_r <= cmd.sc_issue;
      sc_v2_r <= sc_v1_r;
      sc_v3_r <= sc_v2_r && sc_le2_r;
    end
  end

  always_ff @(posedge clk) begin
    sc_fe1_r  <= cmd.sc_first_elem;
    sc_le1_r  <= cmd.sc_last_elem;
    sc_ft1_r  <= cmd.sc_first_tok;
    sc_tok1_r <= tok_idx;
    sc_fe2_r  <= sc_fe1_r;
    sc_le2_r  <= sc_le1_r;
    sc_ft2_r  <= sc_ft1_r;
    sc_tok2_r <= sc_tok1_r;
    sc_ft3_r  <= sc_ft2_r;
    sc_tok3_r <= sc_tok2_r;
    sc_prod_r <= q_rd_r * k_rd_r;
    if (sc_v2_r) begin
      sc_acc_r <= (sc_fe2_r ? SW'(0) : sc_acc_r) + SW'(sc_prod_r);
    end
    if (sc_v3_r && (sc_ft3_r || sc_acc_r > best_r)) begin
      best_r <= sc_acc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (sc_v3_r) begin
      s_mem[sc_tok3_r] <= sc_acc_r;
    end
    if (cmd.ex_issue || cmd.rd_issue) begin
      s_rd_r <= s_mem[s_raddr];
    end
  end

  // exponent pipeline: gap, scale by log2(e), table and shift, sum
  logic             ex_v1_r, ex_v2_r, ex_v3_r;
  logic             ex_f1_r, ex_f2_r, ex_f3_r;
  logic [TIW-1:0]   ex_tok1_r, ex_tok2_r, ex_tok3_r;
  logic [SW-1:0]    ex_gap_r;
  logic             ex_big_r;
  logic [45:0]      ex_prod_r;
  logic [5:0]       ex_ip;
  logic [EW-1:0]    ex_e;
  logic [SUM_W-1:0] sum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ex_v1_r <= 1'b0;
      ex_v2_r <= 1'b0;
      ex_v3_r <= 1'b0;
    end else begin
      ex_v1_r <= cmd.ex_issue;
      ex_v2_r <= ex_v1_r;
      ex_v3_r <= ex_v2_r;
    end
  end

  always_ff @(posedge clk) begin
    ex_f1_r   <= cmd.ex_first;
    ex_tok1_r <= tok_idx;
    ex_f2_r   <= ex_f1_r;
    ex_tok2_r <= ex_tok1_r;
    ex_f3_r   <= ex_f2_r;
    ex_tok3_r <= ex_tok2_r;
    ex_gap_r  <= SW'(best_r - s_rd_r);
    ex_big_r  <= |ex_gap_r[SW-1:29];
    ex_prod_r <= 46'(ex_gap_r[28:0]) * 46'(sha_pkg::LOG2E_Q16);
    if (ex_v3_r) begin
      sum_r <= (ex_f3_r ? SUM_W'(0) : sum_r) + SUM_W'(ex_e);
    end
  end

  assign ex_ip = ex_prod_r[45:40];
  assign ex_e  = (ex_big_r || ex_ip >= 6'd17) ? '0
               : sha_pkg::exp2_frac(ex_prod_r[39:35]) >> ex_ip;

  // normalise: weight = min(65535, e * 65536 / sum)
  logic [DVD_W-1:0] quo;
  logic [15:0]      wt_sat;

  sha_div #(
    .DVD_W (DVD_W),
    .DVS_W (SUM_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.nm_start),
    .dividend ({wt_rd_r, 16'd0}),
    .divisor  (sum_r),
    .busy     (status.div_busy),
    .quotient (quo)
  );

  assign wt_sat = (quo > DVD_W'(16'hFFFF)) ? 16'hFFFF : quo[15:0];

  always_ff @(posedge clk) begin
    if (ex_v3_r) begin
      wt_mem[ex_tok3_r] <= ex_e;
    end else if (cmd.nm_wr) begin
      wt_mem[tok_idx] <= {1'b0, wt_sat};
    end
    if (cmd.nm_rd || cmd.op_issue) begin
      wt_rd_r <= wt_mem[tok_idx];
    end
  end

  // output pipeline: weighted sum of one value column
  logic                     op_v1_r, op_v2_r;
  logic                     op_f1_r, op_f2_r;
  logic signed [32:0]       op_prod_r;
  logic signed [OACC_W-1:0] op_acc_r;
  logic signed [OACC_W:0]   op_rnd;
  logic signed [OACC_W:0]   op_shr;
  logic signed [15:0]       op_sat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_v1_r <= 1'b0;
      op_v2_r <= 1'b0;
    end else begin
      op_v1_r <= cmd.op_issue;
      op_v2_r <= op_v1_r;
    end
  end

  always_ff @(posedge clk) begin
    op_f1_r   <= cmd.op_first;
    op_f2_r   <= op_f1_r;
    op_prod_r <= $signed({1'b0, wt_rd_r[15:0]}) * v_rd_r;
    if (op_v2_r) begin
      op_acc_r <= (op_f2_r ? OACC_W'(0) : op_acc_r) + OACC_W'(op_prod_r);
    end
  end

  // round half up, floor by arithmetic shift, saturate to Q4.12
  always_comb begin
    op_rnd = (OACC_W+1)'(op_acc_r) + (OACC_W+1)'(ROUND_HALF);
    op_shr = op_rnd >>> 16;
    if (op_shr > (OACC_W+1)'(32767)) begin
      op_sat = 16'sh7FFF;
    end else if (op_shr < -(OACC_W+1)'(32768)) begin
      op_sat = -16'sh8000;
    end else begin
      op_sat = 16'(op_shr);
    end
  end

  // read-back tag
  logic [6:0] rd_tok_r;
  logic       rd_ok_r;

  always_ff @(posedge clk) begin
    if (cmd.rd_issue) begin
      rd_tok_r <= in_item.token_index;
      rd_ok_r  <= tok_ok;
    end
  end

  // output register
  logic                 out_valid_r;
  sha_pkg::out_item_t   out_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.op_emit || cmd.rd_emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op_emit) begin
      out_item_r.kind  <= sha_pkg::KIND_OUTPUT;
      out_item_r.index <= 7'(dim_idx);
      out_item_r.value <= SW'(op_sat);
      out_item_r.last  <= cmd.emit_last;
    end else if (cmd.rd_emit) begin
      out_item_r.kind  <= sha_pkg::KIND_SCORE;
      out_item_r.index <= rd_tok_r;
      out_item_r.value <= rd_ok_r ? s_rd_r : SW'(0);
      out_item_r.last  <= 1'b1;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  assign status.pipe_busy = sc_v1_r | sc_v2_r | sc_v3_r | ex_v1_r | ex_v2_r | ex_v3_r
                          | op_v1_r | op_v2_r;
  assign status.out_free  = !out_valid_r || out_ready;

endmodule

>>> sv/single_head_attention_unit.sv
// Loads are accepted at one item per cycle while idle. A score read holds input off until its
// result is placed in the output register, once the output slot is free. A compute pass
// is paced by the one shared key/value read port and the bit-serial divider, and it also
// waits on output stalls. One item is in work at a time; input is held off until a read or
// compute pass is done.
// Reset (rst_n low, synchronous) clears control state, sets token_count 128, dim_count 64.
module single_head_attention_unit #(
  parameter int MAX_TOKENS = sha_pkg::DEF_MAX_TOKENS,
  parameter int MAX_DIM    = sha_pkg::DEF_MAX_DIM
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // command items
  input  logic                           in_valid,
  output logic                           in_ready,
  input  sha_pkg::in_item_t              in_item,
  // result items
  output logic                           out_valid,
  input  logic                           out_ready,
  output sha_pkg::out_item_t             out_item,
  // register writes
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [sha_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sha_pkg::CFG_DAT_W-1:0]  cfg_data
);

  localparam int TIW = (MAX_TOKENS > 1) ? $clog2(MAX_TOKENS) : 1;
  localparam int DIW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

  // controller drives phase commands and loop indices; datapath reports back
  sha_pkg::sha_cmd_t    cmd;
  sha_pkg::sha_status_t status;
  logic [TIW-1:0]       tok_idx;
  logic [DIW-1:0]       dim_idx;

  // sequencer: loads and score reads; compute as scores, exponents, normalise, weighted sums, emit
  sha_ctrl #(
    .MAX_TOKENS (MAX_TOKENS),
    .MAX_DIM    (MAX_DIM)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_cmd    (in_item.cmd),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .status    (status),
    .cmd       (cmd),
    .tok_idx   (tok_idx),
    .dim_idx   (dim_idx)
  );

  // stores, arithmetic pipelines, divider and output register
  sha_dp #(
    .MAX_TOKENS (MAX_TOKENS),
    .MAX_DIM    (MAX_DIM)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cmd       (cmd),
    .tok_idx   (tok_idx),
    .dim_idx   (dim_idx),
    .status    (status),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule
